// ===== rtl/core/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared constants and types for the chunk frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  localparam int CHUNK_BYTES     = 256;
  localparam int MIN_FRAME_BYTES = 9;
  localparam int MAX_RESULTS     = 28;

  localparam int ADDR_W  = $clog2(CHUNK_BYTES);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int WIDE_W  = 17;

  localparam logic [7:0] HEAD_A = 8'hAA;
  localparam logic [7:0] HEAD_B = 8'h55;
  localparam logic [7:0] TAIL_A = 8'h55;
  localparam logic [7:0] TAIL_B = 8'hAA;
  localparam int         FRAMING_BYTES = 6;

  localparam logic [8:0] MAX_PAYLOAD_RESET = 9'd250;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_H0,
    ST_H1,
    ST_L0,
    ST_L1,
    ST_ADR,
    ST_TYP,
    ST_E0,
    ST_E1,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       found;
    logic [7:0] start;
    logic [8:0] total_len;
    logic [7:0] address;
    logic [7:0] ftype;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfd_ram.sv =====
// ----------------------------------------------------------------------------
// cfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/chunk_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// chunk_frame_deframer
// Loads a chunk into RAM, then scans it for AA 55 / len / payload / 55 AA
// frames and reports each one, or a single empty result.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  in_rx_byte, in_chunk_end
//   out_*       out  out_valid/out_stall frame_found/start/total_len/
//                                       address/type, result_last
//   cfg_*       in   cfg_wr_en          cfg_max_payload_len
//
// A byte loads while idle. After the last byte the scan walks the chunk RAM
// through its single read port per offset: first header byte, second header
// byte, length, then a frame's address, type and tail bytes (waiting while
// the output is stalled), then it closes the scan. No byte is taken during
// the scan. Reset (rst_n low, synchronous) clears control state and sets the
// payload limit to 250. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_frame_deframer
  import cfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_chunk_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_frame_found,
  output logic [7:0]      out_frame_start,
  output logic [8:0]      out_frame_total_len,
  output logic [7:0]      out_frame_address,
  output logic [7:0]      out_frame_type,
  output logic            out_result_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_max_payload_len
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   tot_r, tot_nxt;
  logic [RES_W-1:0]   count_r, count_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic [7:0]         adr_r, adr_nxt;
  logic [7:0]         typ_r, typ_nxt;
  logic               pend_v_r, pend_v_nxt;
  res_t               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;
  logic [8:0]         max_r;

  logic               in_xfer;
  logic               out_free;
  logic               wr_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;
  logic [CNT_W-1:0]   len_new;
  logic [WIDE_W-1:0]  payload_w;
  logic [WIDE_W-1:0]  total_w;
  logic               scan_done;
  logic               len_bad;
  logic               over_end;
  logic               push_ok;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign wr_en    = in_xfer && (fill_r < CNT_W'(CHUNK_BYTES));
  assign len_new  = (fill_r < CNT_W'(CHUNK_BYTES)) ? fill_r + CNT_W'(1) : fill_r;

  assign payload_w = WIDE_W'({rd_data, lo_r});
  assign total_w   = payload_w + WIDE_W'(FRAMING_BYTES);
  assign scan_done = (WIDE_W'(pos_r) + WIDE_W'(MIN_FRAME_BYTES) > WIDE_W'(len_r))
                     || (count_r == RES_W'(MAX_RESULTS));
  assign len_bad   = (payload_w > WIDE_W'(max_r)) || (total_w < WIDE_W'(MIN_FRAME_BYTES));
  assign over_end  = (WIDE_W'(pos_r) + total_w) > WIDE_W'(len_r);
  assign push_ok   = !pend_v_r || out_free;

  cfd_ram #(
    .WIDTH (8),
    .DEPTH (CHUNK_BYTES)
  ) u_chunk_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (state_r)
      ST_H0:   rd_addr = ADDR_W'(pos_r + CNT_W'(1));
      ST_H1:   rd_addr = ADDR_W'(pos_r + CNT_W'(2));
      ST_L0:   rd_addr = ADDR_W'(pos_r + CNT_W'(3));
      ST_L1:   rd_addr = ADDR_W'(pos_r + CNT_W'(4));
      ST_ADR:  rd_addr = ADDR_W'(pos_r + CNT_W'(5));
      ST_TYP:  rd_addr = ADDR_W'(pos_r + tot_r - CNT_W'(2));
      ST_E0,
      ST_E1:   rd_addr = ADDR_W'(pos_r + tot_r - CNT_W'(1));
      default: rd_addr = ADDR_W'(pos_r);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_chunk_end) begin
          state_nxt = (len_new >= CNT_W'(MIN_FRAME_BYTES)) ? ST_CHK : ST_FIN;
        end
      end
      ST_CHK:  state_nxt = scan_done ? ST_FIN : ST_H0;
      ST_H0:   state_nxt = (rd_data == HEAD_A) ? ST_H1 : ST_CHK;
      ST_H1:   state_nxt = (rd_data == HEAD_B) ? ST_L0 : ST_CHK;
      ST_L0:   state_nxt = ST_L1;
      ST_L1: begin
        priority if (len_bad) begin
          state_nxt = ST_CHK;
        end else if (over_end) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_ADR;
        end
      end
      ST_ADR:  state_nxt = ST_TYP;
      ST_TYP:  state_nxt = ST_E0;
      ST_E0:   state_nxt = (rd_data == TAIL_A) ? ST_E1 : ST_CHK;
      ST_E1: begin
        if (rd_data != TAIL_B || push_ok) begin
          state_nxt = ST_CHK;
        end
      end
      ST_FIN:  state_nxt = out_free ? ST_IDLE : ST_FIN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    tot_nxt       = tot_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    adr_nxt       = adr_r;
    typ_nxt       = typ_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chunk_end) begin
            fill_nxt   = '0;
            len_nxt    = len_new;
            pos_nxt    = '0;
            count_nxt  = '0;
            pend_v_nxt = 1'b0;
          end else begin
            fill_nxt = len_new;
          end
        end
      end
      ST_H0: begin
        if (rd_data != HEAD_A) begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      ST_H1: begin
        if (rd_data != HEAD_B) begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      ST_L0: lo_nxt = rd_data;
      ST_L1: begin
        tot_nxt = CNT_W'(total_w);
        if (len_bad) begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      ST_ADR: adr_nxt = rd_data;
      ST_TYP: typ_nxt = rd_data;
      ST_E0: begin
        if (rd_data != TAIL_A) begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      ST_E1: begin
        if (rd_data != TAIL_B) begin
          pos_nxt = pos_r + CNT_W'(1);
        end else if (push_ok) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_v_nxt         = 1'b1;
          pend_nxt.found     = 1'b1;
          pend_nxt.start     = 8'(pos_r);
          pend_nxt.total_len = 9'(tot_r);
          pend_nxt.address   = adr_r;
          pend_nxt.ftype     = typ_r;
          pend_nxt.last      = 1'b0;
          pos_nxt            = pos_r + tot_r;
          count_nxt          = count_r + RES_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt = '0;
          end
          out_nxt.last = 1'b1;
          pend_v_nxt   = 1'b0;
          pos_nxt      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= MAX_PAYLOAD_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_max_payload_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    tot_r  <= tot_nxt;
    lo_r   <= lo_nxt;
    adr_r  <= adr_nxt;
    typ_r  <= typ_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_frame_found     = out_r.found;
  assign out_frame_start     = out_r.start;
  assign out_frame_total_len = out_r.total_len;
  assign out_frame_address   = out_r.address;
  assign out_frame_type      = out_r.ftype;
  assign out_result_last     = out_r.last;

endmodule

`default_nettype wire
